// File: rtl/segment_intersection_test_defines.svh
// assertion macros for the segment intersection test block
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

`ifndef SYNTHESIS
`define SIT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SIT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/sit_pkg.sv
// shared coordinate width default and orientation sign type for the segment intersection test
`default_nettype none

package sit_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    // sign of one orientation determinant
    typedef struct packed {
        logic gt;
        logic lt;
    } orient_t;

endpackage

`default_nettype wire

// File: rtl/segment_intersection_test.sv
// segment intersection test: four-stage pipeline over orientation determinants
// an accepted beat passes the stage 1, stage 2 and stage 3 registers, then the output register
// throughput: one segment pair per cycle; the output register and each stage
// hold their beat under back-pressure, and empty stages are filled at once
// reset: rst_n asynchronous, clears all stage valid bits; no other state
`default_nettype none

`include "segment_intersection_test_defines.svh"

module segment_intersection_test
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] b_end_y,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic                          crosses
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DW-1:0]          diff_t;
    typedef logic signed [PW-1:0]          prod_t;

    function automatic diff_t sub(input coord_t hi, input coord_t lo);
        diff_t ehi;
        diff_t elo;
        ehi = {hi[COORD_WIDTH-1], hi};
        elo = {lo[COORD_WIDTH-1], lo};
        return ehi - elo;
    endfunction

    // closed bounding box of segment a-b contains c
    function automatic logic in_box(input coord_t ax, input coord_t ay,
                                    input coord_t bx, input coord_t by,
                                    input coord_t cx, input coord_t cy);
        logic okx;
        logic oky;
        okx = (ax <= cx || bx <= cx) && (cx <= ax || cx <= bx);
        oky = (ay <= cy || by <= cy) && (cy <= ay || cy <= by);
        return okx && oky;
    endfunction

    // stage valid bits and advance enables
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic out_valid_reg, out_valid_next;
    logic en1, en2, en3, en_out;

    // stage 1: differences and box flags
    diff_t ux_reg [4];
    diff_t uy_reg [4];
    diff_t vx_reg [4];
    diff_t vy_reg [4];
    diff_t ux_next [4];
    diff_t uy_next [4];
    diff_t vx_next [4];
    diff_t vy_next [4];
    logic [3:0] box1_reg, box1_next;

    // stage 2: products
    prod_t p_reg [4];
    prod_t q_reg [4];
    prod_t p_next [4];
    prod_t q_next [4];
    logic [3:0] box2_reg;

    // stage 3: determinant signs
    orient_t ori_reg [4];
    orient_t ori_next [4];
    logic [3:0] box3_reg;

    // stage 4: result
    logic crosses_reg, crosses_next;
    logic strict_cross;
    logic [3:0] touch;

    assign en_out   = !out_valid_reg || out_ready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        v1_next        = en1    ? in_valid : v1_reg;
        v2_next        = en2    ? v1_reg   : v2_reg;
        v3_next        = en3    ? v2_reg   : v3_reg;
        out_valid_next = en_out ? v3_reg   : out_valid_reg;
    end

    always_comb
    begin
        // orientation of b_start and b_end against segment a
        ux_next[0] = sub(a_end_x, a_start_x);
        uy_next[0] = sub(a_end_y, a_start_y);
        vx_next[0] = sub(b_start_x, a_start_x);
        vy_next[0] = sub(b_start_y, a_start_y);
        ux_next[1] = sub(a_end_x, a_start_x);
        uy_next[1] = sub(a_end_y, a_start_y);
        vx_next[1] = sub(b_end_x, a_start_x);
        vy_next[1] = sub(b_end_y, a_start_y);
        // orientation of a_start and a_end against segment b
        ux_next[2] = sub(b_end_x, b_start_x);
        uy_next[2] = sub(b_end_y, b_start_y);
        vx_next[2] = sub(a_start_x, b_start_x);
        vy_next[2] = sub(a_start_y, b_start_y);
        ux_next[3] = sub(b_end_x, b_start_x);
        uy_next[3] = sub(b_end_y, b_start_y);
        vx_next[3] = sub(a_end_x, b_start_x);
        vy_next[3] = sub(a_end_y, b_start_y);
        box1_next[0] = in_box(a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y);
        box1_next[1] = in_box(a_start_x, a_start_y, a_end_x, a_end_y, b_end_x, b_end_y);
        box1_next[2] = in_box(b_start_x, b_start_y, b_end_x, b_end_y, a_start_x, a_start_y);
        box1_next[3] = in_box(b_start_x, b_start_y, b_end_x, b_end_y, a_end_x, a_end_y);
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            p_next[k] = PW'(ux_reg[k]) * PW'(vy_reg[k]);
            q_next[k] = PW'(uy_reg[k]) * PW'(vx_reg[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ori_next[k].gt = p_reg[k] > q_reg[k];
            ori_next[k].lt = p_reg[k] < q_reg[k];
        end
    end

    always_comb
    begin
        strict_cross = ((ori_reg[0].gt && ori_reg[1].lt) || (ori_reg[0].lt && ori_reg[1].gt))
                    && ((ori_reg[2].gt && ori_reg[3].lt) || (ori_reg[2].lt && ori_reg[3].gt));
        for (int k = 0; k < 4; k++)
        begin
            touch[k] = !ori_reg[k].gt && !ori_reg[k].lt && box3_reg[k];
        end
        crosses_next = strict_cross || (|touch);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ux_reg   <= ux_next;
            uy_reg   <= uy_next;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            box1_reg <= box1_next;
        end
        if (en2)
        begin
            p_reg    <= p_next;
            q_reg    <= q_next;
            box2_reg <= box1_reg;
        end
        if (en3)
        begin
            ori_reg  <= ori_next;
            box3_reg <= box2_reg;
        end
        if (en_out)
        begin
            crosses_reg <= crosses_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign crosses   = crosses_reg;

    // a stalled product stage keeps its beat
    `SIT_ASSERT_NEXT(a_prod_hold, clk, rst_n, v2_reg && !en2,
        v2_reg && $stable(p_reg[0]) && $stable(q_reg[3]))
    // a beat leaving the sign stage lands in the output register
    `SIT_ASSERT_NEXT(a_sign_to_out, clk, rst_n, v3_reg && en3, out_valid_reg)
    // a strict sign change in both pairs always reports a crossing
    `SIT_ASSERT_NEXT(a_strict_hit, clk, rst_n, v3_reg && en3 && strict_cross, crosses_reg)
    // back-pressure reaches the input only when every stage is full
    `SIT_ASSERT_SAME(a_ready_full, clk, rst_n, !in_ready,
        v1_reg && v2_reg && v3_reg && out_valid_reg)

endmodule

`default_nettype wire

// File: sim/segment_intersection_test_tb.sv
// testbench for segment_intersection_test: directed segment table, then random segment pairs
`default_nettype none

module segment_intersection_test_tb;
    import sit_pkg::*;

    localparam int CW    = COORD_WIDTH_DEF;
    localparam int C_MIN = -(2 ** (CW - 1));
    localparam int C_MAX = 2 ** (CW - 1) - 1;

    typedef logic signed [CW-1:0] coord_t;

    // index 0: a start, 1: a end, 2: b start, 3: b end
    typedef struct {
        coord_t x [4];
        coord_t y [4];
    } seg_pair_t;

    typedef struct {
        seg_pair_t pair;
        bit        typed;
        bit        hit;
    } dir_row_t;

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   out_ready = 1'b0;
    coord_t a_start_x = '0;
    coord_t a_start_y = '0;
    coord_t a_end_x   = '0;
    coord_t a_end_y   = '0;
    coord_t b_start_x = '0;
    coord_t b_start_y = '0;
    coord_t b_end_x   = '0;
    coord_t b_end_y   = '0;
    logic   in_ready;
    logic   out_valid;
    logic   crosses;

    bit       crossing_due [$];
    dir_row_t segment_table [$];
    int       error_count   = 0;
    int       send_idle_pct = 37;
    int       rcv_stall_pct = 37;

    segment_intersection_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crosses   (crosses)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // sign of the turn from o->p towards q
    function automatic int turn_sign(input longint ox, input longint oy, input longint px,
                                     input longint py, input longint qx, input longint qy);
        longint lhs;
        longint rhs;
        lhs = (px - ox) * (qy - oy);
        rhs = (py - oy) * (qx - ox);
        if (lhs > rhs)
            return 1;
        if (lhs < rhs)
            return -1;
        return 0;
    endfunction

    function automatic bit inside_box(input longint ox, input longint oy, input longint px,
                                      input longint py, input longint qx, input longint qy);
        longint lox;
        longint hix;
        longint loy;
        longint hiy;
        lox = (ox < px) ? ox : px;
        hix = (ox < px) ? px : ox;
        loy = (oy < py) ? oy : py;
        hiy = (oy < py) ? py : oy;
        return (lox <= qx) && (qx <= hix) && (loy <= qy) && (qy <= hiy);
    endfunction

    function automatic bit crossing_of(input seg_pair_t p);
        longint x [4];
        longint y [4];
        int     s1;
        int     s2;
        int     s3;
        int     s4;
        for (int j = 0; j < 4; j++)
        begin
            x[j] = p.x[j];
            y[j] = p.y[j];
        end
        s1 = turn_sign(x[0], y[0], x[1], y[1], x[2], y[2]);
        s2 = turn_sign(x[0], y[0], x[1], y[1], x[3], y[3]);
        s3 = turn_sign(x[2], y[2], x[3], y[3], x[0], y[0]);
        s4 = turn_sign(x[2], y[2], x[3], y[3], x[1], y[1]);
        if (s1 * s2 < 0 && s3 * s4 < 0)
            return 1'b1;
        if (s1 == 0 && inside_box(x[0], y[0], x[1], y[1], x[2], y[2]))
            return 1'b1;
        if (s2 == 0 && inside_box(x[0], y[0], x[1], y[1], x[3], y[3]))
            return 1'b1;
        if (s3 == 0 && inside_box(x[2], y[2], x[3], y[3], x[0], y[0]))
            return 1'b1;
        if (s4 == 0 && inside_box(x[2], y[2], x[3], y[3], x[1], y[1]))
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic int rand_signed(input int bits);
        return $signed($urandom) >>> (32 - bits);
    endfunction

    task automatic add_row(input int x0, input int y0, input int x1, input int y1,
                           input int x2, input int y2, input int x3, input int y3,
                           input bit typed, input bit hit);
        dir_row_t r;
        r.pair.x[0] = coord_t'(x0);
        r.pair.y[0] = coord_t'(y0);
        r.pair.x[1] = coord_t'(x1);
        r.pair.y[1] = coord_t'(y1);
        r.pair.x[2] = coord_t'(x2);
        r.pair.y[2] = coord_t'(y2);
        r.pair.x[3] = coord_t'(x3);
        r.pair.y[3] = coord_t'(y3);
        r.typed     = typed;
        r.hit       = hit;
        segment_table.push_back(r);
    endtask

    task automatic send_beat(input seg_pair_t p, input bit want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        a_start_x <= p.x[0];
        a_start_y <= p.y[0];
        a_end_x   <= p.x[1];
        a_end_y   <= p.y[1];
        b_start_x <= p.x[2];
        b_start_y <= p.y[2];
        b_end_x   <= p.x[3];
        b_end_y   <= p.y[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        crossing_due.push_back(want);
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n && out_valid && out_ready)
        begin
            if (crossing_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got crosses %0b", $time, crosses);
                error_count++;
            end
            else
            begin
                want = crossing_due.pop_front();
                if (crosses !== want)
                begin
                    $display("%0t: crosses mismatch, expected %0b, got %0b",
                             $time, want, crosses);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        seg_pair_t pair;
        int        gx [4];
        int        gy [4];
        int        kind;
        int        ox;
        int        oy;
        int        dx;
        int        dy;
        int        n;
        int        k;
        int        tt;
        int        tmp;
        bit        want;

        // plain crossings, touching, collinear and point-sized segments
        add_row(-10, -10, 10, 10, -10, 10, 10, -10, 1'b1, 1'b1);
        add_row(0, 0, 10, 0, 0, 5, 10, 5, 1'b1, 1'b0);
        add_row(0, 0, 10, 0, 10, 0, 20, 5, 1'b1, 1'b1);
        add_row(0, 0, 10, 0, 5, 0, 5, 7, 1'b0, 1'b0);
        add_row(0, 0, 10, 0, 5, 0, 15, 0, 1'b0, 1'b0);
        add_row(0, 0, 10, 0, 11, 0, 20, 0, 1'b0, 1'b0);
        add_row(0, 0, 5, 5, 5, 5, 9, 9, 1'b0, 1'b0);
        add_row(3, 3, 3, 3, 0, 0, 6, 6, 1'b0, 1'b0);
        add_row(3, 4, 3, 4, 0, 0, 6, 6, 1'b0, 1'b0);
        add_row(7, -2, 7, -2, 7, -2, 7, -2, 1'b0, 1'b0);
        add_row(7, -2, 7, -2, 8, -2, 8, -2, 1'b0, 1'b0);
        add_row(0, 0, 10, 10, 0, 10, 4, 6, 1'b0, 1'b0);
        add_row(0, 0, 10, 10, 0, 10, 5, 5, 1'b0, 1'b0);
        add_row(0, 0, 4, 4, 10, 0, 0, 10, 1'b0, 1'b0);
        // extremes of the coordinate range
        add_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 1'b1);
        add_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, 1'b1);
        add_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
        add_row(C_MIN, C_MIN, C_MIN + 1, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX - 1, 1'b1, 1'b0);
        add_row(C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX, 1'b1, 1'b1);
        add_row(C_MIN, C_MAX, -1, C_MAX, 0, C_MAX, C_MAX, C_MAX, 1'b1, 1'b0);
        add_row(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, 1'b0, 1'b0);
        add_row(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, 1'b0);
        add_row(-1, 1, 1, -1, -1, -1, 1, 1, 1'b1, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (segment_table[r])
        begin
            want = segment_table[r].typed ? segment_table[r].hit
                                          : crossing_of(segment_table[r].pair);
            send_beat(segment_table[r].pair, want);
        end

        for (int i = 0; i < 1700; i++)
        begin
            if (i == 600)
            begin
                send_idle_pct = 0;
                rcv_stall_pct = 0;
            end
            if (i == 900)
            begin
                send_idle_pct = 37;
                rcv_stall_pct = 37;
            end
            kind = $urandom_range(99);
            if (kind < 20)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    gx[j] = rand_signed(CW);
                    gy[j] = rand_signed(CW);
                end
            end
            else if (kind < 35)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    gx[j] = rand_signed($urandom_range(1, CW));
                    gy[j] = rand_signed($urandom_range(1, CW));
                end
            end
            else if (kind < 50)
            begin
                // tiny grid: lots of zero turns and shared points
                for (int j = 0; j < 4; j++)
                begin
                    gx[j] = int'($urandom_range(8)) - 4;
                    gy[j] = int'($urandom_range(8)) - 4;
                end
            end
            else if (kind < 65)
            begin
                // all four points on one line
                ox = rand_signed(20);
                oy = rand_signed(20);
                dx = rand_signed(6);
                dy = rand_signed(6);
                for (int j = 0; j < 4; j++)
                begin
                    tt    = int'($urandom_range(60)) - 30;
                    gx[j] = ox + tt * dx;
                    gy[j] = oy + tt * dy;
                end
            end
            else
            begin
                // b start exactly on a, or nudged off by one; kind >= 90 redraws all points
                ox = rand_signed(20);
                oy = rand_signed(20);
                dx = rand_signed(10);
                dy = rand_signed(10);
                n  = $urandom_range(1, 16);
                k  = $urandom_range(0, n);
                gx[0] = ox;
                gy[0] = oy;
                gx[1] = ox + n * dx;
                gy[1] = oy + n * dy;
                gx[2] = ox + k * dx;
                gy[2] = oy + k * dy;
                gx[3] = rand_signed(20);
                gy[3] = rand_signed(20);
                if ($urandom_range(99) < 30)
                begin
                    gx[2] = gx[2] + int'($urandom_range(2)) - 1;
                    gy[2] = gy[2] + int'($urandom_range(2)) - 1;
                end
                if (kind >= 80)
                begin
                    // point-sized segments
                    gx[3] = gx[2];
                    gy[3] = gy[2];
                    if ($urandom_range(1))
                    begin
                        gx[1] = gx[0];
                        gy[1] = gy[0];
                    end
                end
                if (kind >= 90)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        case ($urandom_range(7))
                            0: gx[j] = C_MIN;
                            1: gx[j] = C_MAX;
                            2: gx[j] = 0;
                            3: gx[j] = -1;
                            4: gx[j] = C_MIN + 1;
                            5: gx[j] = C_MAX - 1;
                            default: gx[j] = rand_signed(CW);
                        endcase
                        case ($urandom_range(7))
                            0: gy[j] = C_MIN;
                            1: gy[j] = C_MAX;
                            2: gy[j] = 0;
                            3: gy[j] = 1;
                            4: gy[j] = C_MIN + 1;
                            5: gy[j] = C_MAX - 1;
                            default: gy[j] = rand_signed(CW);
                        endcase
                    end
                end
            end
            // shuffle segment order and endpoint order
            if ($urandom_range(1))
            begin
                for (int j = 0; j < 2; j++)
                begin
                    tmp       = gx[j];
                    gx[j]     = gx[j + 2];
                    gx[j + 2] = tmp;
                    tmp       = gy[j];
                    gy[j]     = gy[j + 2];
                    gy[j + 2] = tmp;
                end
            end
            for (int j = 0; j < 4; j += 2)
            begin
                if ($urandom_range(1))
                begin
                    tmp       = gx[j];
                    gx[j]     = gx[j + 1];
                    gx[j + 1] = tmp;
                    tmp       = gy[j];
                    gy[j]     = gy[j + 1];
                    gy[j + 1] = tmp;
                end
            end
            for (int j = 0; j < 4; j++)
            begin
                pair.x[j] = coord_t'(gx[j]);
                pair.y[j] = coord_t'(gy[j]);
            end
            send_beat(pair, crossing_of(pair));
        end

        in_valid <= 1'b0;
        while (crossing_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
